FILE: hw/rtl/rau_pkg.sv
package rau_pkg;

   localparam int NUM_W = 34;
   localparam int DEN_W = 33;
   localparam int OP_W  = 3;
   localparam int CMP_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_CMP = 3'd4
   } op_type;

   localparam logic [CMP_W-1:0] CMP_LESS    = 2'd0;
   localparam logic [CMP_W-1:0] CMP_EQUAL   = 2'd1;
   localparam logic [CMP_W-1:0] CMP_GREATER = 2'd2;

   typedef enum logic [1:0] {
      KIND_ZERO,
      KIND_ERROR,
      KIND_REDUCE,
      KIND_CMP
   } kind_type;

endpackage

FILE: hw/rtl/rau_front.sv
module rau_front #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [rau_pkg::OP_W-1:0]       in_type,
   input  logic signed [OPERAND_WIDTH-1:0] in_a_num,
   input  logic signed [OPERAND_WIDTH-1:0] in_a_den,
   input  logic signed [OPERAND_WIDTH-1:0] in_b_num,
   input  logic signed [OPERAND_WIDTH-1:0] in_b_den,
   output logic                           out_valid,
   input  logic                           out_ready,
   output rau_pkg::kind_type              out_kind,
   output logic [2*OPERAND_WIDTH+1:0]     out_num,
   output logic [2*OPERAND_WIDTH:0]       out_den,
   output logic [rau_pkg::CMP_W-1:0]      out_cmp
);
   import rau_pkg::*;

   localparam int PW = 2 * OPERAND_WIDTH + 2;

   logic                    s1_valid_ff, s1_valid_in;
   logic [OP_W-1:0]         s1_op_ff;
   logic signed [PW-1:0]    s1_p0_ff, s1_p1_ff, s1_p2_ff, s1_p3_ff;
   logic                    s1_adz_ff, s1_bdz_ff;
   logic                    s2_valid_ff;
   kind_type                s2_kind_ff, s2_kind_in;
   logic [PW-1:0]           s2_num_ff, s2_num_in;
   logic [PW-2:0]           s2_den_ff, s2_den_in;
   logic [CMP_W-1:0]        s2_cmp_ff, s2_cmp_in;
   logic                    s1_adv;
   logic signed [PW-1:0]    an, ad, bn, bd, nn, dd, lhs, rhs;
   logic signed [PW-1:0]    a_n, a_d, b_n, b_d;

   assign s1_adv   = !s2_valid_ff || out_ready;
   assign in_ready = !s1_valid_ff || s1_adv;
   assign s1_valid_in = in_valid ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   always_comb begin
      an = PW'(in_a_num);
      ad = PW'(in_a_den);
      bn = PW'(in_b_num);
      bd = PW'(in_b_den);
      a_n = ad < 0 ? -an : an;
      a_d = ad < 0 ? -ad : ad;
      b_n = bd < 0 ? -bn : bn;
      b_d = bd < 0 ? -bd : bd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (in_ready) begin
         s1_valid_ff <= s1_valid_in;
      end
      if (in_ready && in_valid) begin
         s1_op_ff  <= in_type;
         s1_adz_ff <= (in_a_den == '0);
         s1_bdz_ff <= (in_b_den == '0);
         unique case (in_type)
            OP_MUL: begin
               s1_p0_ff <= an * bn;
               s1_p1_ff <= '0;
               s1_p2_ff <= ad * bd;
               s1_p3_ff <= '0;
            end
            OP_DIV: begin
               s1_p0_ff <= an * bd;
               s1_p1_ff <= '0;
               s1_p2_ff <= ad * bn;
               s1_p3_ff <= '0;
            end
            OP_CMP: begin
               s1_p0_ff <= a_n * b_d;
               s1_p1_ff <= b_n * a_d;
               s1_p2_ff <= '0;
               s1_p3_ff <= '0;
            end
            default: begin
               s1_p0_ff <= an * bd;
               s1_p1_ff <= bn * ad;
               s1_p2_ff <= ad * bd;
               s1_p3_ff <= '0;
            end
         endcase
      end
   end

   always_comb begin
      lhs = s1_p0_ff;
      rhs = s1_p1_ff;
      nn  = '0;
      dd  = s1_p2_ff + s1_p3_ff;
      s2_kind_in = KIND_ZERO;
      s2_num_in  = '0;
      s2_den_in  = '0;
      s2_cmp_in  = CMP_LESS;
      unique case (s1_op_ff)
         OP_ADD: nn = s1_p0_ff + s1_p1_ff;
         OP_SUB: nn = s1_p0_ff - s1_p1_ff;
         OP_MUL, OP_DIV: nn = s1_p0_ff;
         default: nn = '0;
      endcase
      if (s1_op_ff == OP_CMP) begin
         if (s1_adz_ff || s1_bdz_ff) begin
            s2_kind_in = KIND_ERROR;
         end else begin
            s2_kind_in = KIND_CMP;
            s2_cmp_in = (lhs < rhs) ? CMP_LESS : ((lhs == rhs) ? CMP_EQUAL : CMP_GREATER);
         end
      end else if (s1_op_ff <= OP_DIV) begin
         if (dd == 0) begin
            s2_kind_in = KIND_ERROR;
         end else if (nn == 0) begin
            s2_kind_in = KIND_ZERO;
            s2_den_in  = (PW-1)'(1);
         end else begin
            s2_kind_in = KIND_REDUCE;
            s2_num_in  = (dd < 0) ? -nn : nn;
            s2_den_in  = (PW-1)'((dd < 0) ? -dd : dd);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s1_adv && s1_valid_ff) begin
         s2_kind_ff <= s2_kind_in;
         s2_num_ff  <= s2_num_in;
         s2_den_ff  <= s2_den_in;
         s2_cmp_ff  <= s2_cmp_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_kind  = s2_kind_ff;
   assign out_num   = s2_num_ff;
   assign out_den   = s2_den_ff;
   assign out_cmp   = s2_cmp_ff;
endmodule

FILE: hw/rtl/rau_queue.sv
module rau_queue #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [W-1:0] in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [W-1:0] out_data
);
   logic [W-1:0] mem_ff [2];
   logic         wr_ff, rd_ff;
   logic [1:0]   cnt_ff;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (in_valid && in_ready) begin
            wr_ff <= ~wr_ff;
         end
         if (out_valid && out_ready) begin
            rd_ff <= ~rd_ff;
         end
         cnt_ff <= cnt_ff + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
      end
      if (in_valid && in_ready) begin
         mem_ff[wr_ff] <= in_data;
      end
   end
endmodule

FILE: hw/rtl/rau_back.sv
module rau_back #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  rau_pkg::kind_type           in_kind,
   input  logic [2*OPERAND_WIDTH+1:0]  in_num,
   input  logic [2*OPERAND_WIDTH:0]    in_den,
   input  logic [rau_pkg::CMP_W-1:0]   in_cmp,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [rau_pkg::NUM_W-1:0]   out_num,
   output logic [rau_pkg::DEN_W-1:0]   out_den,
   output logic [rau_pkg::CMP_W-1:0]   out_cmp,
   output logic                        out_status
);
   import rau_pkg::*;

   localparam int PW = 2 * OPERAND_WIDTH + 2;
   localparam int MW = PW - 1;
   localparam int SW = $clog2(MW + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SHIFT, ST_GCD, ST_DIVN, ST_DIVD, ST_DONE
   } state_type;

   state_type            state_ff;
   logic                 neg_ff;
   logic [MW-1:0]        n_ff, d_ff, u_ff, v_ff, g_ff;
   logic [SW-1:0]        sh_ff;
   logic [MW-1:0]        quo_ff, rem_ff, dvd_ff;
   logic [SW-1:0]        bit_ff;
   logic [MW-1:0]        qn_ff;
   logic [NUM_W-1:0]     rnum_ff;
   logic [DEN_W-1:0]     rden_ff;
   logic [CMP_W-1:0]     rcmp_ff;
   logic                 rst_ff;
   logic [MW-1:0]        mag, rem_sh, quo_n;
   logic signed [PW-1:0] neg_q;
   logic                 ge;

   assign in_ready  = (state_ff == ST_IDLE);
   assign out_valid = (state_ff == ST_DONE);
   assign out_num   = rnum_ff;
   assign out_den   = rden_ff;
   assign out_cmp   = rcmp_ff;
   assign out_status = rst_ff;

   always_comb begin
      mag    = in_num[PW-1] ? MW'(-in_num) : MW'(in_num);
      rem_sh = {rem_ff[MW-2:0], dvd_ff[MW-1]};
      ge     = (rem_sh >= g_ff);
      quo_n  = {quo_ff[MW-2:0], ge};
      neg_q  = neg_ff ? -PW'(qn_ff) : PW'(qn_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (in_valid) begin
                  unique case (in_kind)
                     KIND_ZERO: begin
                        rnum_ff  <= '0;
                        rden_ff  <= DEN_W'(in_den);
                        rcmp_ff  <= CMP_LESS;
                        rst_ff   <= 1'b0;
                        state_ff <= ST_DONE;
                     end
                     KIND_ERROR: begin
                        rnum_ff  <= '0;
                        rden_ff  <= '0;
                        rcmp_ff  <= CMP_LESS;
                        rst_ff   <= 1'b1;
                        state_ff <= ST_DONE;
                     end
                     KIND_CMP: begin
                        rnum_ff  <= '0;
                        rden_ff  <= '0;
                        rcmp_ff  <= in_cmp;
                        rst_ff   <= 1'b0;
                        state_ff <= ST_DONE;
                     end
                     KIND_REDUCE: begin
                        rcmp_ff  <= CMP_LESS;
                        rst_ff   <= 1'b0;
                        neg_ff   <= in_num[PW-1];
                        n_ff     <= mag;
                        d_ff     <= in_den[MW-1:0];
                        u_ff     <= mag;
                        v_ff     <= in_den[MW-1:0];
                        sh_ff    <= '0;
                        state_ff <= ST_SHIFT;
                     end
                  endcase
               end
            end
            ST_SHIFT: begin
               if (((u_ff | v_ff) & MW'(1)) == '0) begin
                  u_ff  <= u_ff >> 1;
                  v_ff  <= v_ff >> 1;
                  sh_ff <= sh_ff + SW'(1);
               end else if (!u_ff[0]) begin
                  u_ff <= u_ff >> 1;
               end else begin
                  state_ff <= ST_GCD;
               end
            end
            ST_GCD: begin
               if (v_ff == '0) begin
                  g_ff     <= u_ff << sh_ff;
                  dvd_ff   <= n_ff;
                  rem_ff   <= '0;
                  quo_ff   <= '0;
                  bit_ff   <= '0;
                  state_ff <= ST_DIVN;
               end else if (!v_ff[0]) begin
                  v_ff <= v_ff >> 1;
               end else if (u_ff > v_ff) begin
                  u_ff <= v_ff;
                  v_ff <= u_ff - v_ff;
               end else begin
                  v_ff <= v_ff - u_ff;
               end
            end
            ST_DIVN, ST_DIVD: begin
               if (bit_ff == SW'(MW - 1)) begin
                  rem_ff <= '0;
                  quo_ff <= '0;
                  bit_ff <= '0;
                  if (state_ff == ST_DIVN) begin
                     qn_ff    <= quo_n;
                     dvd_ff   <= d_ff;
                     state_ff <= ST_DIVD;
                  end else begin
                     rnum_ff  <= NUM_W'(neg_q);
                     rden_ff  <= DEN_W'(quo_n);
                     state_ff <= ST_DONE;
                  end
               end else begin
                  rem_ff <= ge ? rem_sh - g_ff : rem_sh;
                  quo_ff <= quo_n;
                  dvd_ff <= dvd_ff << 1;
                  bit_ff <= bit_ff + SW'(1);
               end
            end
            ST_DONE: begin
               if (out_ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

FILE: hw/rtl/rational_arith_unit.sv
// Rational ALU: add, subtract, multiply, divide or compare two signed fractions,
// reducing the result by its GCD with the sign on the numerator. The front end
// forms cross products in a two-stage pipeline and classifies each transaction;
// a two-entry queue feeds the back end. Compare, zero and error results go
// straight to the done state of the back end; reduced results take the binary
// GCD plus two restoring divisions of 2*OPERAND_WIDTH+1 bits each.
module rational_arith_unit #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [rau_pkg::OP_W-1:0]        req_type,
   input  logic signed [OPERAND_WIDTH-1:0] req_a_num,
   input  logic signed [OPERAND_WIDTH-1:0] req_a_den,
   input  logic signed [OPERAND_WIDTH-1:0] req_b_num,
   input  logic signed [OPERAND_WIDTH-1:0] req_b_den,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [rau_pkg::NUM_W-1:0] rsp_res_num,
   output logic [rau_pkg::DEN_W-1:0]       rsp_res_den,
   output logic [rau_pkg::CMP_W-1:0]       rsp_cmp_result,
   output logic                            rsp_status
);
   import rau_pkg::*;

   localparam int PW = 2 * OPERAND_WIDTH + 2;
   localparam int QW = 2 + PW + (PW - 1) + CMP_W;

   logic            f_valid, f_ready, b_valid, b_ready;
   kind_type        f_kind, b_kind;
   logic [PW-1:0]   f_num, b_num;
   logic [PW-2:0]   f_den, b_den;
   logic [CMP_W-1:0] f_cmp, b_cmp;
   logic [QW-1:0]   q_out;

   rau_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(req_ready), .in_type(req_type),
      .in_a_num(req_a_num), .in_a_den(req_a_den),
      .in_b_num(req_b_num), .in_b_den(req_b_den),
      .out_valid(f_valid), .out_ready(f_ready), .out_kind(f_kind),
      .out_num(f_num), .out_den(f_den), .out_cmp(f_cmp)
   );

   rau_queue #(.W(QW)) u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready),
      .in_data({f_kind, f_num, f_den, f_cmp}),
      .out_valid(b_valid), .out_ready(b_ready), .out_data(q_out)
   );

   assign b_kind = kind_type'(q_out[QW-1 -: 2]);
   assign b_num  = q_out[QW-3 -: PW];
   assign b_den  = q_out[CMP_W +: PW-1];
   assign b_cmp  = q_out[CMP_W-1:0];

   rau_back #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_back (
      .clock(clock), .reset(reset),
      .in_valid(b_valid), .in_ready(b_ready), .in_kind(b_kind),
      .in_num(b_num), .in_den(b_den), .in_cmp(b_cmp),
      .out_valid(rsp_valid), .out_ready(rsp_ready),
      .out_num(rsp_res_num), .out_den(rsp_res_den),
      .out_cmp(rsp_cmp_result), .out_status(rsp_status)
   );
endmodule
